>>> sv/spt_pkg.sv
// spt_pkg: shared types, codes and helpers for the stable priority table.
// Used by spt_ctrl, spt_dpath, stable_priority_table_core and spt_port_chk.
// No dependencies.
package spt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned TOP_W        = 7;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_BUMP   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_TOP    = 3'd3,
    OP_LIST   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_BUMP_WR,
    ST_SHIFT,
    ST_LIST,
    ST_TOP_SCAN,
    ST_TOP_EMIT
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic        [DATA_W-1:0] key;
    logic        [DATA_W-1:0] note;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture request fields
    logic add_wr;       // append entry (dropped when full)
    logic scan_clr;     // restart table scan
    logic top_init;     // clear used flags and round count
    logic rd_go;        // issue next read if any entries remain
    logic rd_pop;       // drop held read data
    logic bump_wr;      // write saturated sum back
    logic shift_wr;     // move held entry one slot down
    logic top_cmp;      // fold held entry into best-so-far
    logic out_load;     // load output register
    logic out_sel_best; // output source: best entry, else read data
    logic mark_used;    // flag best entry as emitted
    logic cnt_dec;      // one entry removed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  in_op;
    op_e  op;
    logic top_none;
    logic hit;
    logic scan_done;
    logic rd_vld;
    logic out_free;
    logic last_round;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

>>> sv/spt_ctrl.sv
// spt_ctrl: operation sequencer for the stable priority table.
// Depends on spt_pkg; drives spt_dpath through cmd_t, reads status_t.
module spt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  spt_pkg::status_t sts_i,
  output spt_pkg::cmd_t    cmd_o
);

  spt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != spt_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.in_op)
            spt_pkg::OP_BUMP,
            spt_pkg::OP_REMOVE: state_d = spt_pkg::ST_FIND;
            spt_pkg::OP_TOP:    state_d = sts_i.top_none ? spt_pkg::ST_IDLE
                                                         : spt_pkg::ST_TOP_SCAN;
            spt_pkg::OP_LIST:   state_d = spt_pkg::ST_LIST;
            default:            state_d = spt_pkg::ST_IDLE;
          endcase
        end
      end
      spt_pkg::ST_FIND: begin
        if (sts_i.hit) begin
          state_d = (sts_i.op == spt_pkg::OP_BUMP) ? spt_pkg::ST_BUMP_WR : spt_pkg::ST_SHIFT;
        end else if (sts_i.scan_done) begin
          state_d = spt_pkg::ST_IDLE;
        end
      end
      spt_pkg::ST_BUMP_WR: state_d = spt_pkg::ST_IDLE;
      spt_pkg::ST_SHIFT: begin
        if (sts_i.scan_done) state_d = spt_pkg::ST_IDLE;
      end
      spt_pkg::ST_LIST: begin
        if (sts_i.scan_done) state_d = spt_pkg::ST_IDLE;
      end
      spt_pkg::ST_TOP_SCAN: begin
        if (sts_i.scan_done) state_d = spt_pkg::ST_TOP_EMIT;
      end
      spt_pkg::ST_TOP_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_round ? spt_pkg::ST_IDLE : spt_pkg::ST_TOP_SCAN;
        end
      end
      default: state_d = spt_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      spt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch    = 1'b1;
          cmd_o.scan_clr = 1'b1;
          cmd_o.add_wr   = (sts_i.in_op == spt_pkg::OP_ADD);
          cmd_o.top_init = (sts_i.in_op == spt_pkg::OP_TOP);
        end
      end
      spt_pkg::ST_FIND: begin
        // on a hit, keep the matched entry for the bump write; remove drops it
        cmd_o.rd_go  = !sts_i.hit;
        cmd_o.rd_pop = !sts_i.hit || (sts_i.op == spt_pkg::OP_REMOVE);
      end
      spt_pkg::ST_BUMP_WR: begin
        cmd_o.bump_wr = 1'b1;
        cmd_o.rd_pop  = 1'b1;
      end
      spt_pkg::ST_SHIFT: begin
        cmd_o.rd_go    = 1'b1;
        cmd_o.rd_pop   = 1'b1;
        cmd_o.shift_wr = 1'b1;
        cmd_o.cnt_dec  = sts_i.scan_done;
      end
      spt_pkg::ST_LIST: begin
        cmd_o.rd_go    = !sts_i.rd_vld || sts_i.out_free;
        cmd_o.rd_pop   = sts_i.out_free;
        cmd_o.out_load = sts_i.rd_vld && sts_i.out_free;
      end
      spt_pkg::ST_TOP_SCAN: begin
        cmd_o.rd_go   = 1'b1;
        cmd_o.rd_pop  = 1'b1;
        cmd_o.top_cmp = 1'b1;
      end
      spt_pkg::ST_TOP_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel_best = 1'b1;
          cmd_o.mark_used    = 1'b1;
          cmd_o.scan_clr     = !sts_i.last_round;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/spt_dpath.sv
// spt_dpath: entry memory, scan pointer, read stage, best-entry tracker and
// output register of the stable priority table. Depends on spt_pkg.
module spt_dpath #(
  parameter int unsigned CAPACITY = spt_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spt_pkg::cmd_t                     cmd_i,
  output spt_pkg::status_t                  sts_o,
  input  logic [2:0]                        operation_i,
  input  logic [spt_pkg::DATA_W-1:0]        title_key_i,
  input  logic signed [spt_pkg::DATA_W-1:0] new_priority_i,
  input  logic signed [spt_pkg::DATA_W-1:0] bump_amount_i,
  input  logic [spt_pkg::TOP_W-1:0]         top_count_i,
  input  logic [spt_pkg::DATA_W-1:0]        note_handle_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [spt_pkg::DATA_W-1:0] entry_priority_out_o,
  output logic [spt_pkg::DATA_W-1:0]        entry_key_out_o,
  output logic [spt_pkg::DATA_W-1:0]        entry_note_out_o,
  output logic                              last_of_run_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  spt_pkg::entry_t mem [CAPACITY];

  logic [CW-1:0]               count_q, ptr_q, limit_q, round_q;
  logic                        rd_vld_q;
  logic [IW-1:0]               rd_idx_q, best_idx_q;
  spt_pkg::entry_t             rd_q, best_q, out_q;
  spt_pkg::op_e                op_q;
  logic [spt_pkg::DATA_W-1:0]  key_q;
  logic signed [spt_pkg::DATA_W-1:0] delta_q;
  logic [CAPACITY-1:0]         used_q;
  logic                        best_vld_q, out_vld_q, out_last_q;

  logic                        rd_en, add_ok, wr_en, best_upd, greater;
  logic                        list_last, out_free;
  logic [IW-1:0]               wr_addr;
  spt_pkg::entry_t             wr_data;
  logic [spt_pkg::TOP_W-1:0]   cnt_ext, lim;

  assign rd_en    = cmd_i.rd_go && (ptr_q < count_q);
  assign add_ok   = cmd_i.add_wr && (count_q < CW'(CAPACITY));
  assign out_free = !out_vld_q || !out_stall_i;

  assign greater  = !best_vld_q || ($signed(rd_q.prio) > $signed(best_q.prio));
  assign best_upd = cmd_i.top_cmp && rd_vld_q && !used_q[rd_idx_q] && greater;

  assign list_last = ((CW'(rd_idx_q) + CW'(1)) == count_q);

  assign cnt_ext = spt_pkg::TOP_W'(count_q);
  assign lim     = (top_count_i < cnt_ext) ? top_count_i : cnt_ext;

  // write port: append, bump write-back or gap closing
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx_q;
    wr_data = rd_q;
    priority if (add_ok) begin
      wr_en        = 1'b1;
      wr_addr      = count_q[IW-1:0];
      wr_data.prio = new_priority_i;
      wr_data.key  = title_key_i;
      wr_data.note = note_handle_i;
    end else if (cmd_i.bump_wr) begin
      wr_en        = 1'b1;
      wr_data.prio = spt_pkg::sat_add(rd_q.prio, delta_q);
    end else if (cmd_i.shift_wr && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q - IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q     <= mem[ptr_q[IW-1:0]];
      rd_idx_q <= ptr_q[IW-1:0];
    end
  end

  // request fields, best-entry payload and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= spt_pkg::op_e'(operation_i);
      key_q   <= title_key_i;
      delta_q <= bump_amount_i;
      limit_q <= CW'(lim);
    end
    if (best_upd) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.out_load) begin
      out_q      <= cmd_i.out_sel_best ? best_q : rd_q;
      out_last_q <= cmd_i.out_sel_best ? sts_o.last_round : list_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ptr_q      <= '0;
      rd_vld_q   <= 1'b0;
      used_q     <= '0;
      round_q    <= '0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (add_ok)            count_q <= count_q + CW'(1);
      else if (cmd_i.cnt_dec) count_q <= count_q - CW'(1);

      if (cmd_i.scan_clr) ptr_q <= '0;
      else if (rd_en)     ptr_q <= ptr_q + CW'(1);

      if (cmd_i.scan_clr)  rd_vld_q <= 1'b0;
      else if (rd_en)      rd_vld_q <= 1'b1;
      else if (cmd_i.rd_pop) rd_vld_q <= 1'b0;

      if (cmd_i.scan_clr) best_vld_q <= 1'b0;
      else if (best_upd)  best_vld_q <= 1'b1;

      if (cmd_i.top_init) begin
        used_q  <= '0;
        round_q <= '0;
      end else if (cmd_i.mark_used) begin
        used_q[best_idx_q] <= 1'b1;
        round_q            <= round_q + CW'(1);
      end

      if (cmd_i.out_load)  out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_op      = spt_pkg::op_e'(operation_i);
    sts_o.op         = op_q;
    sts_o.top_none   = (top_count_i == '0) || (count_q == '0);
    sts_o.hit        = rd_vld_q && (rd_q.key == key_q);
    sts_o.scan_done  = !rd_vld_q && (ptr_q == count_q);
    sts_o.rd_vld     = rd_vld_q;
    sts_o.out_free   = out_free;
    sts_o.last_round = ((round_q + CW'(1)) == limit_q);
  end

  assign out_valid_o          = out_vld_q;
  assign entry_priority_out_o = out_q.prio;
  assign entry_key_out_o      = out_q.key;
  assign entry_note_out_o     = out_q.note;
  assign last_of_run_o        = out_last_q;

endmodule

>>> sv/stable_priority_table_core.sv
// Stable priority table: up to CAPACITY entries (priority, key, note) kept in
// insertion order. Operations: add, bump by key (saturating), remove by key,
// list all, emit top N by descending priority (earlier entry wins a tie).
// Input channel: in_valid_i / in_stall_o, one request per accepted edge.
// Output channel: out_valid_o / out_stall_i, one entry per result; list and
// top runs mark their final entry with last_of_run_o.
// Sequencing: add and unused codes leave the block idle. Bump and remove
// scan the entry memory at one entry per cycle until the key is found; bump
// then writes the saturated sum back, remove moves the entries behind the gap
// down one per cycle. A key that is not found leaves the table unchanged.
// List streams one entry per cycle while the receiver does not stall. Top
// runs one full table scan per emitted entry.
// The output is a one-deep register, so a new request is taken while the
// last result waits. A stalled receiver holds the result and pauses the
// list or top run without loss. Requests are taken only between operations.
// Reset empties the table at once; no clearing pass is needed.
module stable_priority_table_core #(
  parameter int unsigned CAPACITY = spt_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        operation_i,
  input  logic [spt_pkg::DATA_W-1:0]        title_key_i,
  input  logic signed [spt_pkg::DATA_W-1:0] new_priority_i,
  input  logic signed [spt_pkg::DATA_W-1:0] bump_amount_i,
  input  logic [spt_pkg::TOP_W-1:0]         top_count_i,
  input  logic [spt_pkg::DATA_W-1:0]        note_handle_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spt_pkg::DATA_W-1:0] entry_priority_out_o,
  output logic [spt_pkg::DATA_W-1:0]        entry_key_out_o,
  output logic [spt_pkg::DATA_W-1:0]        entry_note_out_o,
  output logic                              last_of_run_o
);

  spt_pkg::cmd_t    cmd;
  spt_pkg::status_t sts;

  spt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .operation_i          (operation_i),
    .title_key_i          (title_key_i),
    .new_priority_i       (new_priority_i),
    .bump_amount_i        (bump_amount_i),
    .top_count_i          (top_count_i),
    .note_handle_i        (note_handle_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .entry_priority_out_o (entry_priority_out_o),
    .entry_key_out_o      (entry_key_out_o),
    .entry_note_out_o     (entry_note_out_o),
    .last_of_run_o        (last_of_run_o)
  );

endmodule

>>> sv/spt_port_chk.sv
// spt_port_chk: port-level checks for stable_priority_table_core, bound to it
// below. Depends on spt_pkg.
module spt_port_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [2:0]                        operation_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [spt_pkg::DATA_W-1:0] entry_priority_out_o,
  input logic [spt_pkg::DATA_W-1:0]        entry_key_out_o,
  input logic [spt_pkg::DATA_W-1:0]        entry_note_out_o,
  input logic                              last_of_run_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_priority_out_o)
      && $stable(entry_key_out_o) && $stable(entry_note_out_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // add and unused codes finish in the accept cycle
  a_add_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == spt_pkg::OP_ADD || operation_i > spt_pkg::OP_LIST)
      |=> !in_stall_o)
    else $error("single-cycle request left the block busy");

  // bump and remove always scan
  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (operation_i == spt_pkg::OP_BUMP || operation_i == spt_pkg::OP_REMOVE)
      |=> in_stall_o)
    else $error("bump/remove did not start a scan");

  // results are only produced while an operation is in progress
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside a list/top run");

endmodule

bind stable_priority_table_core spt_port_chk u_port_chk (.*);

>>> dv/stable_priority_table_core_test.sv
// Testbench for stable_priority_table_core: a directed stimulus table, then random requests.
// Every result is checked against a behavioral model of the entry table.
// Depends on spt_pkg and stable_priority_table_core.
module stable_priority_table_core_test;

  localparam int unsigned CAP          = spt_pkg::CAPACITY_DEF;
  localparam int          RANDOM_REQS  = 90;
  localparam int          MAX_WAIT     = 18;
  localparam int          DRAIN_CYCLES = 400;
  localparam longint      LIMIT_TIME   = 64'd9_600_000;
  localparam int          N_DIRECTED   = 28;

  localparam logic [2:0]                 OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]                 OP_UNUSED_HI = 3'd7;
  localparam logic [spt_pkg::DATA_W-1:0] P_MAX        = 32'h7fff_ffff;
  localparam logic [spt_pkg::DATA_W-1:0] P_MIN        = 32'h8000_0000;

  typedef struct packed {
    logic signed [spt_pkg::DATA_W-1:0] prio;
    logic [spt_pkg::DATA_W-1:0]        key;
    logic [spt_pkg::DATA_W-1:0]        note;
    logic                              last;
  } result_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic [spt_pkg::DATA_W-1:0] key;
    logic [spt_pkg::DATA_W-1:0] prio;
    logic [spt_pkg::DATA_W-1:0] bump;
    logic [spt_pkg::TOP_W-1:0]  cnt;
    logic [spt_pkg::DATA_W-1:0] note;
    logic [4:0]                 times;  // row is sent this many times, key, note and priority stepped
    logic                       typed;  // expectation below is used instead of the model
    logic [4:0]                 n_exp;
    result_t                    exp;
  } row_t;

  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{spt_pkg::OP_LIST,   32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd64, 32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_BUMP,   32'h5,         32'h0, 32'h1,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_REMOVE, 32'h5,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_ADD,    32'hffff_ffff, P_MAX, 32'h0,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd1,  32'h0,         5'd1,  1'b1,
      5'd1, '{P_MAX, 32'hffff_ffff, 32'h0, 1'b1}},
    '{spt_pkg::OP_BUMP,   32'hffff_ffff, 32'h0, P_MAX,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_LIST,   32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd1, '{P_MAX, 32'hffff_ffff, 32'h0, 1'b1}},
    '{spt_pkg::OP_ADD,    32'h0,         P_MIN, 32'h0,         7'd64, 32'hffff_ffff, 5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_BUMP,   32'h0,         32'h0, P_MIN,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd64, 32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_ADD,    32'h1,         32'h0, 32'h0,         7'd0,  32'ha5a5_a5a5, 5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_ADD,    32'h2,         32'h0, 32'h0,         7'd0,  32'h5a5a_5a5a, 5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_ADD,    32'h1,         32'h5, 32'h0,         7'd0,  32'h0000_1111, 5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_BUMP,   32'h1,         32'h0, 32'hffff_fffb, 7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd3,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_REMOVE, 32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_LIST,   32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{OP_UNUSED_LO,       32'h1,         P_MAX, P_MAX,         7'd64, 32'hffff_ffff, 5'd1,  1'b1,
      5'd0, '0},
    '{OP_UNUSED_HI,       32'h2,         P_MIN, P_MIN,         7'd63, 32'h1234_5678, 5'd1,  1'b1,
      5'd0, '0},
    '{spt_pkg::OP_ADD,    32'h100,       32'h3, 32'h0,         7'd0,  32'h200,       5'd13, 1'b0,
      5'd0, '0},
    '{spt_pkg::OP_LIST,   32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_TOP,    32'h0,         32'h0, 32'h0,         7'd64, 32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_REMOVE, 32'h10c,       32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_REMOVE, 32'h10b,       32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_REMOVE, 32'hffff_ffff, 32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0},
    '{spt_pkg::OP_LIST,   32'h0,         32'h0, 32'h0,         7'd0,  32'h0,         5'd1,  1'b0,
      5'd0, '0}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid;
  logic                              in_stall;
  logic [2:0]                        operation;
  logic [spt_pkg::DATA_W-1:0]        title_key;
  logic signed [spt_pkg::DATA_W-1:0] new_priority;
  logic signed [spt_pkg::DATA_W-1:0] bump_amount;
  logic [spt_pkg::TOP_W-1:0]         top_count;
  logic [spt_pkg::DATA_W-1:0]        note_handle;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [spt_pkg::DATA_W-1:0] entry_priority;
  logic [spt_pkg::DATA_W-1:0]        entry_key;
  logic [spt_pkg::DATA_W-1:0]        entry_note;
  logic                              last_of_run;

  // model of the entry table
  spt_pkg::entry_t tbl [CAP];
  int              tbl_count;
  result_t         step_out [$];
  result_t         pending_results [$];

  int req_count;
  int res_count;
  int err_count;
  int dropped_adds;
  int saturated_bumps;

  stable_priority_table_core #(
    .CAPACITY(CAP)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .operation_i         (operation),
    .title_key_i         (title_key),
    .new_priority_i      (new_priority),
    .bump_amount_i       (bump_amount),
    .top_count_i         (top_count),
    .note_handle_i       (note_handle),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .entry_priority_out_o(entry_priority),
    .entry_key_out_o     (entry_key),
    .entry_note_out_o    (entry_note),
    .last_of_run_o       (last_of_run)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // quiet stretches: every third block of requests or results runs with no idling
  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [spt_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return P_MAX;
      1:       return P_MIN;
      2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic result_t as_result(int idx, bit last);
    result_t r;
    r.prio = tbl[idx].prio;
    r.key  = tbl[idx].key;
    r.note = tbl[idx].note;
    r.last = last;
    return r;
  endfunction

  // apply one request to the table model; emitted entries land in step_out
  task automatic table_apply(input logic [2:0] op,
                             input logic [spt_pkg::DATA_W-1:0] key, prio, bump,
                             input logic [spt_pkg::TOP_W-1:0] cnt,
                             input logic [spt_pkg::DATA_W-1:0] note);
    int     hit;
    int     limit;
    int     best;
    longint sum;
    bit     taken [CAP];
    step_out.delete();
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl[i].key == key) hit = i;
    end
    case (op)
      spt_pkg::OP_ADD: begin
        if (tbl_count < CAP) begin
          tbl[tbl_count].prio = prio;
          tbl[tbl_count].key  = key;
          tbl[tbl_count].note = note;
          tbl_count++;
        end else begin
          dropped_adds++;
        end
      end
      spt_pkg::OP_BUMP: begin
        if (hit >= 0) begin
          sum = longint'($signed(tbl[hit].prio)) + longint'($signed(bump));
          if (sum > longint'($signed(P_MAX))) begin
            sum = longint'($signed(P_MAX));
            saturated_bumps++;
          end else if (sum < longint'($signed(P_MIN))) begin
            sum = longint'($signed(P_MIN));
            saturated_bumps++;
          end
          tbl[hit].prio = sum[spt_pkg::DATA_W-1:0];
        end
      end
      spt_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          for (int j = hit; j + 1 < tbl_count; j++) tbl[j] = tbl[j + 1];
          tbl_count--;
        end
      end
      spt_pkg::OP_TOP: begin
        limit = (int'(cnt) < tbl_count) ? int'(cnt) : tbl_count;
        foreach (taken[j]) taken[j] = 1'b0;
        for (int r = 0; r < limit; r++) begin
          best = -1;
          // strict greater keeps the earlier entry on a tie
          for (int j = 0; j < tbl_count; j++) begin
            if (!taken[j] && (best < 0 || $signed(tbl[j].prio) > $signed(tbl[best].prio)))
              best = j;
          end
          taken[best] = 1'b1;
          step_out.push_back(as_result(best, r + 1 == limit));
        end
      end
      spt_pkg::OP_LIST: begin
        for (int i = 0; i < tbl_count; i++) step_out.push_back(as_result(i, i + 1 == tbl_count));
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [2:0] op,
                              input logic [spt_pkg::DATA_W-1:0] key, prio, bump,
                              input logic [spt_pkg::TOP_W-1:0] cnt,
                              input logic [spt_pkg::DATA_W-1:0] note);
    int gap;
    gap = draw_wait(((req_count / 20) % 3) == 2);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation    <= op;
    title_key    <= key;
    new_priority <= prio;
    bump_amount  <= bump;
    top_count    <= cnt;
    note_handle  <= note;
    in_valid     <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    req_count++;
    table_apply(op, key, prio, bump, cnt, note);
  endtask

  function automatic void check_field(string name, logic [spt_pkg::DATA_W-1:0] want,
                                      logic [spt_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      res_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got prio %h key %h note %h last %b",
                 $time, entry_priority, entry_key, entry_note, last_of_run);
        err_count++;
      end else begin
        check_field("entry_priority", pending_results[0].prio, entry_priority);
        check_field("entry_key", pending_results[0].key, entry_key);
        check_field("entry_note", pending_results[0].note, entry_note);
        check_field("last_of_run", {31'b0, pending_results[0].last}, {31'b0, last_of_run});
        void'(pending_results.pop_front());
      end
    end
  end

  // receiver: stall drawn per result, changes only at the falling edge
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = draw_wait(((res_count / 24) % 3) == 2);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  initial begin
    row_t                       row;
    logic [2:0]                 op;
    logic [spt_pkg::DATA_W-1:0] key_pool [8];
    logic [spt_pkg::TOP_W-1:0]  cnt;
    int                         pick;
    int                         add_cut;

    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    operation    = spt_pkg::OP_ADD;
    title_key    = '0;
    new_priority = '0;
    bump_amount  = '0;
    top_count    = '0;
    note_handle  = '0;
    tbl_count    = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[7] = 32'hffff_ffff;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED[r];
      for (int i = 0; i < int'(row.times); i++) begin
        send_request(row.op, row.key + i, row.prio + (i % 4), row.bump, row.cnt, row.note + i);
        if (row.typed) begin
          if (step_out.size() != int'(row.n_exp) || (row.n_exp == 1 && step_out[0] !== row.exp))
          begin
            $display("%0t: directed row %0d: expected %0d results, table model gives %0d",
                     $time, r, row.n_exp, step_out.size());
            err_count++;
          end
          if (row.n_exp == 1) pending_results.push_back(row.exp);
        end else begin
          foreach (step_out[k]) pending_results.push_back(step_out[k]);
        end
      end
    end

    // random part: keys mostly from a small pool so bumps and removes find their entry
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick    = $urandom_range(0, 99);
      add_cut = (tbl_count == CAP) ? 15 : 40;
      if (pick < add_cut)  op = spt_pkg::OP_ADD;
      else if (pick < 58)  op = spt_pkg::OP_BUMP;
      else if (pick < 74)  op = spt_pkg::OP_REMOVE;
      else if (pick < 88)  op = spt_pkg::OP_TOP;
      else if (pick < 96)  op = spt_pkg::OP_LIST;
      else                 op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      if ($urandom_range(0, 3) == 0) cnt = 7'($urandom_range(0, 64));
      else                           cnt = 7'($urandom_range(1, tbl_count + 1));
      send_request(op, ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, 7)],
                   pick_value(), pick_value(), cnt, $urandom);
      foreach (step_out[k]) pending_results.push_back(step_out[k]);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests (%0d directed rows, %0d random), %0d results checked.",
             req_count, N_DIRECTED, RANDOM_REQS, res_count);
    $display("Adds dropped on a full table: %0d, saturated bumps: %0d, errors: %0d.",
             dropped_adds, saturated_bumps, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_TIME);
    $display("%0t: timeout with %0d results still expected", $time, pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
sv/spt_pkg.sv
sv/spt_ctrl.sv
sv/spt_dpath.sv
sv/stable_priority_table_core.sv
sv/spt_port_chk.sv
dv/stable_priority_table_core_test.sv
